// ===== rtl/hlsrgb_pkg.sv =====
package hlsrgb_pkg;

  // Piece of the hue ramp that an angle falls into.
  typedef enum logic [1:0] {
    REG_RISE,
    REG_HIGH,
    REG_FALL,
    REG_LOW
  } region_t;

  // Load enables of the six pipeline stages.
  typedef struct packed {
    logic st1;
    logic st2;
    logic st3;
    logic st4;
    logic st5;
    logic st6;
  } stage_en_t;

endpackage

// ===== rtl/hlsrgb_if.sv =====
interface hlsrgb_in_if #(
  parameter int FRACTION_BITS     = 16,
  parameter int HUE_FRACTION_BITS = 6
);
  localparam int QW = FRACTION_BITS + 1;
  localparam int HW = $clog2(360 << HUE_FRACTION_BITS);

  logic          valid;
  logic          ready;
  logic [HW-1:0] hue;
  logic [QW-1:0] lightness;
  logic [QW-1:0] saturation;

  modport source (output valid, hue, lightness, saturation, input ready);
  modport sink (input valid, hue, lightness, saturation, output ready);
endinterface

interface hlsrgb_out_if #(
  parameter int FRACTION_BITS = 16
);
  localparam int QW = FRACTION_BITS + 1;

  logic          valid;
  logic          ready;
  logic [QW-1:0] red;
  logic [QW-1:0] green;
  logic [QW-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

// ===== rtl/hlsrgb_prep.sv =====
// Stages 1 and 2: input clamping, hue wrap, l*s product and channel angles.
module hlsrgb_prep #(
  parameter int FRACTION_BITS     = 16,
  parameter int HUE_FRACTION_BITS = 6,
  localparam int QW = FRACTION_BITS + 1,
  localparam int HW = $clog2(360 << HUE_FRACTION_BITS)
) (
  input  logic                  clk,
  input  hlsrgb_pkg::stage_en_t en,
  input  logic [HW-1:0]         hue,
  input  logic [QW-1:0]         lightness,
  input  logic [QW-1:0]         saturation,
  output logic [QW-1:0]         l,
  output logic [QW-1:0]         s,
  output logic [QW-1:0]         ls,
  output logic [2:0][HW-1:0]    ang
);

  localparam int TURN  = 360 << HUE_FRACTION_BITS;
  localparam int THIRD = 120 << HUE_FRACTION_BITS;
  localparam int ONE   = 1 << FRACTION_BITS;

  logic [HW-1:0]   h1;
  logic [QW-1:0]   l1;
  logic [QW-1:0]   s1;
  logic [2*QW-1:0] prod;
  logic [HW:0]     h_plus;

  // The input range is below two turns, so one subtraction wraps it.
  always_ff @(posedge clk) begin
    if (en.st1) begin
      h1 <= (hue >= HW'(TURN)) ? hue - HW'(TURN) : hue;
      l1 <= (lightness > QW'(ONE)) ? QW'(ONE) : lightness;
      s1 <= (saturation > QW'(ONE)) ? QW'(ONE) : saturation;
    end
  end

  assign prod   = l1 * s1;
  assign h_plus = {1'b0, h1} + (HW+1)'(THIRD);

  always_ff @(posedge clk) begin
    if (en.st2) begin
      l      <= l1;
      s      <= s1;
      ls     <= prod[FRACTION_BITS +: QW];
      ang[0] <= (h1 >= HW'(THIRD)) ? h1 - HW'(THIRD) : h1 + HW'(TURN - THIRD);
      ang[1] <= h1;
      ang[2] <= (h_plus >= (HW+1)'(TURN)) ? HW'(h_plus - (HW+1)'(TURN)) : HW'(h_plus);
    end
  end

endmodule

// ===== rtl/hlsrgb_levels.sv =====
// Stage 3: the two ramp levels and, per channel, the ramp piece and its offset.
module hlsrgb_levels #(
  parameter int FRACTION_BITS     = 16,
  parameter int HUE_FRACTION_BITS = 6,
  localparam int QW = FRACTION_BITS + 1,
  localparam int HW = $clog2(360 << HUE_FRACTION_BITS),
  localparam int XW = $clog2((60 << HUE_FRACTION_BITS) + 1)
) (
  input  logic                          clk,
  input  hlsrgb_pkg::stage_en_t         en,
  input  logic [QW-1:0]                 l,
  input  logic [QW-1:0]                 s,
  input  logic [QW-1:0]                 ls,
  input  logic [2:0][HW-1:0]            ang,
  output logic [QW-1:0]                 lo,
  output logic [QW-1:0]                 hi,
  output logic [QW-1:0]                 span,
  output hlsrgb_pkg::region_t [2:0]     region,
  output logic [2:0][XW-1:0]            x
);

  localparam int ONE = 1 << FRACTION_BITS;
  localparam int SIX = 60 << HUE_FRACTION_BITS;

  logic                     half;
  logic [QW:0]              m2_raw;
  logic [QW-1:0]            m2;
  logic signed [QW+1:0]     m1_raw;
  logic [QW-1:0]            m1;
  logic [QW-1:0]            lo_next;
  logic [QW-1:0]            hi_next;
  hlsrgb_pkg::region_t [2:0] region_next;
  logic [2:0][XW-1:0]       x_next;
  logic [HW-1:0]            fall_off;

  always_comb begin
    half   = (l <= QW'(ONE >> 1));
    m2_raw = half ? ({1'b0, l} + {1'b0, ls}) : ({1'b0, l} + {1'b0, s} - {1'b0, ls});
    m2     = (m2_raw > (QW+1)'(ONE)) ? QW'(ONE) : m2_raw[QW-1:0];
    m1_raw = $signed({1'b0, l, 1'b0}) - $signed({2'b00, m2});
    if (m1_raw < 0) begin
      m1 = '0;
    end else if (m1_raw > (QW+2)'(ONE)) begin
      m1 = QW'(ONE);
    end else begin
      m1 = m1_raw[QW-1:0];
    end
    // With no saturation both levels sit at the lightness, so every
    // piece of the ramp gives grey.
    if (s == '0) begin
      lo_next = l;
      hi_next = l;
    end else begin
      lo_next = m1;
      hi_next = m2;
    end
  end

  always_comb begin
    fall_off = '0;
    for (int i = 0; i < 3; i++) begin
      fall_off = HW'(4 * SIX) - ang[i];
      if (ang[i] < HW'(SIX)) begin
        region_next[i] = hlsrgb_pkg::REG_RISE;
        x_next[i]      = ang[i][XW-1:0];
      end else if (ang[i] < HW'(3 * SIX)) begin
        region_next[i] = hlsrgb_pkg::REG_HIGH;
        x_next[i]      = '0;
      end else if (ang[i] < HW'(4 * SIX)) begin
        region_next[i] = hlsrgb_pkg::REG_FALL;
        x_next[i]      = fall_off[XW-1:0];
      end else begin
        region_next[i] = hlsrgb_pkg::REG_LOW;
        x_next[i]      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.st3) begin
      lo     <= lo_next;
      hi     <= hi_next;
      span   <= hi_next - lo_next;
      region <= region_next;
      x      <= x_next;
    end
  end

endmodule

// ===== rtl/hlsrgb_ramp.sv =====
// Stages 4 to 6 of one channel: span times offset, division by sixty
// degrees through a reciprocal product, then the final level select.
module hlsrgb_ramp #(
  parameter int FRACTION_BITS     = 16,
  parameter int HUE_FRACTION_BITS = 6,
  localparam int QW = FRACTION_BITS + 1,
  localparam int XW = $clog2((60 << HUE_FRACTION_BITS) + 1)
) (
  input  logic                  clk,
  input  hlsrgb_pkg::stage_en_t en,
  input  logic [QW-1:0]         lo,
  input  logic [QW-1:0]         hi,
  input  logic [QW-1:0]         span,
  input  hlsrgb_pkg::region_t   region,
  input  logic [XW-1:0]         x,
  output logic [QW-1:0]         value
);

  // Sixty degrees is fifteen times four times the hue unit: the power of
  // two is a shift, the fifteen a reciprocal multiply with one correction.
  localparam int PW    = QW + XW;
  localparam int NW    = PW - HUE_FRACTION_BITS - 2;
  localparam int MW    = NW - 3;
  localparam int SW    = ((QW > MW) ? QW : MW) + 1;
  localparam int ONE   = 1 << FRACTION_BITS;
  localparam int Odd   = 15;
  localparam logic [MW-1:0] RECIP = MW'((64'd1 << NW) / 64'd15);

  logic [PW-1:0]        p4;
  logic [QW-1:0]        lo4;
  logic [QW-1:0]        hi4;
  hlsrgb_pkg::region_t  rg4;
  logic [NW-1:0]        n;
  logic [NW+MW-1:0]     prod5;
  logic [NW-1:0]        n5;
  logic [QW-1:0]        lo5;
  logic [QW-1:0]        hi5;
  hlsrgb_pkg::region_t  rg5;
  logic [MW-1:0]        q0;
  logic [NW-1:0]        rem;
  logic [MW-1:0]        q;
  logic [SW-1:0]        sum;
  logic [QW-1:0]        sloped;
  logic [QW-1:0]        value_next;

  always_ff @(posedge clk) begin
    if (en.st4) begin
      p4  <= span * x;
      lo4 <= lo;
      hi4 <= hi;
      rg4 <= region;
    end
  end

  assign n = p4[PW-1:HUE_FRACTION_BITS+2];

  always_ff @(posedge clk) begin
    if (en.st5) begin
      prod5 <= n * RECIP;
      n5    <= n;
      lo5   <= lo4;
      hi5   <= hi4;
      rg5   <= rg4;
    end
  end

  always_comb begin
    q0  = prod5[NW+MW-1:NW];
    // The estimate is at most one short of the true quotient.
    rem = n5 - ((NW'(q0) << 4) - NW'(q0));
    q   = (rem >= NW'(Odd)) ? q0 + MW'(1) : q0;
    sum = SW'(lo5) + SW'(q);
    sloped = (sum > SW'(ONE)) ? QW'(ONE) : sum[QW-1:0];
    case (rg5)
      hlsrgb_pkg::REG_RISE,
      hlsrgb_pkg::REG_FALL: value_next = sloped;
      hlsrgb_pkg::REG_HIGH: value_next = hi5;
      default:              value_next = lo5;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en.st6) begin
      value <= value_next;
    end
  end

endmodule

// ===== rtl/hls_to_rgb_converter.sv =====
// Channel   Direction  Request payload                      Handshake
// pix_in    in         hue, lightness, saturation           valid / ready
// pix_out   out        red, green, blue                     valid / ready
//
// A color passes through six register stages, and a new request is taken
// every cycle while the output side keeps up. The depth is set by the chain
// of l*s product, level computation, span product and reciprocal divide.
// Reset clears only the stage valid bits; payload registers are not reset.
// A stage loads whenever it is empty or the stage after it moves, so a
// stall at the output backs up one stage at a time and nothing is dropped.
module hls_to_rgb_converter #(
  parameter int FRACTION_BITS     = 16,
  parameter int HUE_FRACTION_BITS = 6
) (
  input logic          clk,
  input logic          rst,
  hlsrgb_in_if.sink    pix_in,
  hlsrgb_out_if.source pix_out
);

  localparam int QW  = FRACTION_BITS + 1;
  localparam int HW  = $clog2(360 << HUE_FRACTION_BITS);
  localparam int XW  = $clog2((60 << HUE_FRACTION_BITS) + 1);
  localparam int ONE = 1 << FRACTION_BITS;

  hlsrgb_pkg::stage_en_t      en;
  logic [5:0]                 vld;

  logic [QW-1:0]              l;
  logic [QW-1:0]              s;
  logic [QW-1:0]              ls;
  logic [2:0][HW-1:0]         ang;
  logic [QW-1:0]              lvl_lo;
  logic [QW-1:0]              lvl_hi;
  logic [QW-1:0]              span;
  hlsrgb_pkg::region_t [2:0]  region;
  logic [2:0][XW-1:0]         x;

  // Each stage takes new data when it holds nothing or its contents move
  // on; the last stage moves when the consumer takes the result.
  always_comb begin
    en.st6 = !vld[5] || pix_out.ready;
    en.st5 = !vld[4] || en.st6;
    en.st4 = !vld[3] || en.st5;
    en.st3 = !vld[2] || en.st4;
    en.st2 = !vld[1] || en.st3;
    en.st1 = !vld[0] || en.st2;
  end

  assign pix_in.ready  = en.st1;
  assign pix_out.valid = vld[5];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en.st1) vld[0] <= pix_in.valid;
      if (en.st2) vld[1] <= vld[0];
      if (en.st3) vld[2] <= vld[1];
      if (en.st4) vld[3] <= vld[2];
      if (en.st5) vld[4] <= vld[3];
      if (en.st6) vld[5] <= vld[4];
    end
  end

  // Stages 1 and 2: clamp the inputs, wrap the hue, form l*s and the
  // three channel angles (hue - 120, hue, hue + 120 degrees).
  hlsrgb_prep #(
    .FRACTION_BITS    (FRACTION_BITS),
    .HUE_FRACTION_BITS(HUE_FRACTION_BITS)
  ) u_prep (
    .clk       (clk),
    .en        (en),
    .hue       (pix_in.hue),
    .lightness (pix_in.lightness),
    .saturation(pix_in.saturation),
    .l         (l),
    .s         (s),
    .ls        (ls),
    .ang       (ang)
  );

  // Stage 3: low and high ramp levels, and where each angle sits on the ramp.
  hlsrgb_levels #(
    .FRACTION_BITS    (FRACTION_BITS),
    .HUE_FRACTION_BITS(HUE_FRACTION_BITS)
  ) u_levels (
    .clk   (clk),
    .en    (en),
    .l     (l),
    .s     (s),
    .ls    (ls),
    .ang   (ang),
    .lo    (lvl_lo),
    .hi    (lvl_hi),
    .span  (span),
    .region(region),
    .x     (x)
  );

  // Stages 4 to 6: one ramp evaluator per output channel.
  hlsrgb_ramp #(
    .FRACTION_BITS    (FRACTION_BITS),
    .HUE_FRACTION_BITS(HUE_FRACTION_BITS)
  ) u_ramp_red (
    .clk   (clk),
    .en    (en),
    .lo    (lvl_lo),
    .hi    (lvl_hi),
    .span  (span),
    .region(region[0]),
    .x     (x[0]),
    .value (pix_out.red)
  );

  hlsrgb_ramp #(
    .FRACTION_BITS    (FRACTION_BITS),
    .HUE_FRACTION_BITS(HUE_FRACTION_BITS)
  ) u_ramp_green (
    .clk   (clk),
    .en    (en),
    .lo    (lvl_lo),
    .hi    (lvl_hi),
    .span  (span),
    .region(region[1]),
    .x     (x[1]),
    .value (pix_out.green)
  );

  hlsrgb_ramp #(
    .FRACTION_BITS    (FRACTION_BITS),
    .HUE_FRACTION_BITS(HUE_FRACTION_BITS)
  ) u_ramp_blue (
    .clk   (clk),
    .en    (en),
    .lo    (lvl_lo),
    .hi    (lvl_hi),
    .span  (span),
    .region(region[2]),
    .x     (x[2]),
    .value (pix_out.blue)
  );

  // Requests are refused only when every stage holds a color.
  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !pix_in.ready |-> (&vld))
    else $error("input blocked while the pipeline has an empty stage");

  // The low level never lies above the high level.
  a_level_order: assert property (@(posedge clk) disable iff (rst)
    vld[2] |-> (lvl_lo <= lvl_hi))
    else $error("ramp levels out of order");

  // Results stay within zero to one.
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    pix_out.valid |-> (pix_out.red <= QW'(ONE)) && (pix_out.green <= QW'(ONE))
                      && (pix_out.blue <= QW'(ONE)))
    else $error("result above full scale");

  // A taken result with nothing behind it leaves the output empty.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (pix_out.valid && pix_out.ready && !vld[4]) |=> !pix_out.valid)
    else $error("result repeated after it was taken");

endmodule

// ===== bench/hls_to_rgb_converter_test.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the HLS to RGB color converter.
//
// Every request that the converter accepts is run through a behavioral
// predictor written here, and the predicted color is queued. Each result
// that leaves the converter is checked, channel by channel, against the
// oldest queued color. A result with nothing queued is a failure, and a
// queued color that never arrives ends the run through the cycle limit.
//
// The tests are run in turn from one initial block. They share one task
// that offers a request and paces the sender in bursts, and one process
// that checks each result. The receiver stalls on its own schedule, which
// each test picks: always ready, random stalls, a rotating pattern, and a
// long hold-off that fills the pipeline and stalls the input side.
module hls_to_rgb_converter_test;

  localparam int HUE_W = 15;
  localparam int Q_W   = 17;

  // Fixed-point constants of the color math.
  localparam longint Q_ONE = 64'd1 << 16;
  localparam longint DEG   = 64'd1 << 6;
  localparam longint TURN  = 360 * DEG;
  localparam int Q_ONE_I   = 1 << 16;
  localparam int TURN_I    = 360 * 64;

  // Hard ceiling on the run length, well above the slowest correct run.
  localparam int CYCLE_LIMIT = 400000;

  // How the receiver decides to take a result on a given cycle.
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PATTERN
  } rx_mode_t;

  typedef struct packed {
    logic [Q_W-1:0] red;
    logic [Q_W-1:0] green;
    logic [Q_W-1:0] blue;
  } rgb_t;

  logic clk;
  logic rst;

  hlsrgb_in_if #(.FRACTION_BITS(16), .HUE_FRACTION_BITS(6)) pix_in ();
  hlsrgb_out_if #(.FRACTION_BITS(16)) pix_out ();

  hls_to_rgb_converter #(
    .FRACTION_BITS    (16),
    .HUE_FRACTION_BITS(6)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .pix_in (pix_in),
    .pix_out(pix_out)
  );

  // Colors predicted for accepted requests, oldest first.
  rgb_t expected_rgb_q[$];

  int mismatch_count = 0;
  int results_seen   = 0;
  int cycle_count    = 0;

  // Sender pacing: a burst of back-to-back requests, then a random gap.
  int tx_max_gap    = 0;
  int tx_max_burst  = 1;
  int tx_burst_left = 0;

  // Receiver schedule. A nonzero hold_request makes the receiver refuse
  // results for a stretch set by its value, counted in the receiver process.
  rx_mode_t   rx_mode      = RX_ALWAYS;
  int         rx_stall_pct = 0;
  logic [7:0] rx_pattern   = 8'hff;
  int         hold_request = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic longint limit_to_one(longint v);
    if (v < 0) begin
      return 0;
    end
    if (v > Q_ONE) begin
      return Q_ONE;
    end
    return v;
  endfunction

  // Level of the hue ramp at angle x, which is already within one turn.
  // The span is never negative, so division truncates toward zero either way.
  function automatic longint ramp_level(longint lo, longint hi, longint x);
    longint span;
    longint lvl;
    span = hi - lo;
    if (x < 60 * DEG) begin
      lvl = lo + (span * x) / (60 * DEG);
    end else if (x < 180 * DEG) begin
      lvl = hi;
    end else if (x < 240 * DEG) begin
      lvl = lo + (span * (240 * DEG - x)) / (60 * DEG);
    end else begin
      lvl = lo;
    end
    return limit_to_one(lvl);
  endfunction

  function automatic rgb_t hls_color_to_rgb(logic [HUE_W-1:0] hue_in,
                                            logic [Q_W-1:0] l_in,
                                            logic [Q_W-1:0] s_in);
    longint h;
    longint l;
    longint s;
    longint ls;
    longint m1;
    longint m2;
    rgb_t   c;
    h = hue_in;
    h = h % TURN;
    l = l_in;
    l = limit_to_one(l);
    s = s_in;
    s = limit_to_one(s);
    if (s == 0) begin
      // No saturation: a grey at the lightness.
      c.red   = Q_W'(l);
      c.green = Q_W'(l);
      c.blue  = Q_W'(l);
    end else begin
      ls = (l * s) >>> 16;
      if (2 * l <= Q_ONE) begin
        m2 = l + ls;
      end else begin
        m2 = l + s - ls;
      end
      m2 = limit_to_one(m2);
      m1 = limit_to_one(2 * l - m2);
      c.red   = Q_W'(ramp_level(m1, m2, (h + TURN - 120 * DEG) % TURN));
      c.green = Q_W'(ramp_level(m1, m2, h));
      c.blue  = Q_W'(ramp_level(m1, m2, (h + 120 * DEG) % TURN));
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------

  // Predict the color for every request the converter takes. Values are
  // sampled at the edge, before any nonblocking update of that edge.
  always @(posedge clk) begin
    if (!rst && pix_in.valid === 1'b1 && pix_in.ready === 1'b1) begin
      expected_rgb_q.push_back(hls_color_to_rgb(pix_in.hue, pix_in.lightness,
                                                pix_in.saturation));
    end
  end

  // Offer one request and return at the edge where it is taken. Valid is
  // left high so that the next request can follow on the very next cycle;
  // it is only lowered for a gap between bursts or when the sender stops.
  task automatic send_color(input logic [HUE_W-1:0] hue_val,
                            input logic [Q_W-1:0] light_val,
                            input logic [Q_W-1:0] sat_val);
    int gap;
    if (tx_burst_left == 0) begin
      gap = $urandom_range(tx_max_gap, 0);
      if (gap > 0) begin
        pix_in.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      tx_burst_left = $urandom_range(tx_max_burst, 1);
    end
    tx_burst_left--;
    pix_in.valid      <= 1'b1;
    pix_in.hue        <= hue_val;
    pix_in.lightness  <= light_val;
    pix_in.saturation <= sat_val;
    do begin
      @(posedge clk);
    end while (pix_in.ready !== 1'b1);
  endtask

  // Stop offering and wait until every predicted color has come back.
  // This is called at the edge where the last request was taken, so it
  // is the only update of valid in that time step. The queue is first
  // looked at on the next edge, once the last request has been predicted.
  task automatic wait_for_results();
    pix_in.valid <= 1'b0;
    tx_burst_left = 0;
    do begin
      @(posedge clk);
    end while (expected_rgb_q.size() != 0);
  endtask

  // Hue mostly within one turn, sometimes anywhere the field allows, and
  // now and then right on a ramp corner.
  function automatic logic [HUE_W-1:0] pick_hue();
    int corner;
    case ($urandom_range(9, 0))
      0: begin
        return HUE_W'($urandom_range(32767, 0));
      end
      1: begin
        corner = 60 * 64 * $urandom_range(6, 0);
        return HUE_W'(corner + $urandom_range(1, 0) - (corner > 0 ? 1 : 0));
      end
      default: begin
        return HUE_W'($urandom_range(TURN_I - 1, 0));
      end
    endcase
  endfunction

  // Lightness or saturation: mostly within 0..1, with the edges, the
  // half point and values above one mixed in.
  function automatic logic [Q_W-1:0] pick_level();
    case ($urandom_range(19, 0))
      0: begin
        return '0;
      end
      1: begin
        return Q_W'(Q_ONE_I);
      end
      2: begin
        return Q_W'(Q_ONE_I / 2);
      end
      3: begin
        return Q_W'(Q_ONE_I / 2 + 1);
      end
      4: begin
        return Q_W'($urandom_range(131071, Q_ONE_I + 1));
      end
      5: begin
        return Q_W'($urandom_range(131071, 0));
      end
      6: begin
        return Q_W'($urandom_range(15, 1));
      end
      default: begin
        return Q_W'($urandom_range(Q_ONE_I, 0));
      end
    endcase
  endfunction

  task automatic send_random_colors(input int count);
    repeat (count) begin
      send_color(pick_hue(), pick_level(), pick_level());
    end
  endtask

  // ---------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------

  // The receiver drives ready on its own schedule. A hold-off request
  // overrides the schedule for the length asked.
  initial begin : receiver
    int hold_left;
    int phase;
    hold_left = 0;
    phase     = 0;
    pix_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        pix_out.ready <= 1'b0;
        hold_left--;
      end else begin
        case (rx_mode)
          RX_ALWAYS: begin
            pix_out.ready <= 1'b1;
          end
          RX_RANDOM: begin
            pix_out.ready <= ($urandom_range(99, 0) >= rx_stall_pct);
          end
          default: begin
            pix_out.ready <= rx_pattern[phase % 8];
          end
        endcase
      end
      phase++;
    end
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
    end
  endtask

  always @(posedge clk) begin : check_result
    rgb_t want;
    if (!rst && pix_out.valid === 1'b1 && pix_out.ready === 1'b1) begin
      results_seen++;
      if (expected_rgb_q.size() == 0) begin
        report_mismatch($sformatf("result with no request outstanding, got %0d %0d %0d",
                                  pix_out.red, pix_out.green, pix_out.blue));
      end else begin
        want = expected_rgb_q.pop_front();
        if (pix_out.red !== want.red) begin
          report_mismatch($sformatf("red expected %0d, got %0d", want.red, pix_out.red));
        end
        if (pix_out.green !== want.green) begin
          report_mismatch($sformatf("green expected %0d, got %0d",
                                    want.green, pix_out.green));
        end
        if (pix_out.blue !== want.blue) begin
          report_mismatch($sformatf("blue expected %0d, got %0d", want.blue, pix_out.blue));
        end
      end
    end
  end

  // A hung pipeline or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("hls_to_rgb_converter_test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Hand-picked colors: greys, the primaries, each ramp corner and the
  // samples just below it, hue at and past one turn, lightness at
  // and just past one half, and inputs above 1.0 that must be clipped.
  task automatic test_directed_colors();
    rx_mode      = RX_RANDOM;
    rx_stall_pct = 20;
    tx_max_gap   = 2;
    tx_max_burst = 4;
    // Greys, including a lightness above one with no saturation.
    send_color(15'd0, 17'd0, 17'd0);
    send_color(15'd0, 17'd65536, 17'd0);
    send_color(15'd5000, 17'd131071, 17'd0);
    send_color(15'd5000, 17'd40000, 17'd0);
    // Fully saturated primaries at half lightness.
    send_color(15'd0, 17'd32768, 17'd65536);
    send_color(15'd7680, 17'd32768, 17'd65536);
    send_color(15'd15360, 17'd32768, 17'd65536);
    // Ramp corners at 60, 180 and 240 degrees and their neighbors.
    send_color(15'd3839, 17'd32768, 17'd65536);
    send_color(15'd3840, 17'd32768, 17'd65536);
    send_color(15'd11519, 17'd32768, 17'd65536);
    send_color(15'd11520, 17'd32768, 17'd65536);
    send_color(15'd15359, 17'd32768, 17'd65536);
    send_color(15'd23039, 17'd32768, 17'd65536);
    // Hue exactly one turn, and the largest value the field can hold.
    send_color(15'd23040, 17'd32768, 17'd65536);
    send_color(15'd32767, 17'd32768, 17'd65536);
    // The two branches of the upper level around a lightness of one half.
    send_color(15'd1000, 17'd32768, 17'd40000);
    send_color(15'd1000, 17'd32769, 17'd40000);
    // Lightness and saturation at and above one.
    send_color(15'd9000, 17'd65536, 17'd65536);
    send_color(15'd9000, 17'd131071, 17'd131071);
    send_color(15'd9000, 17'd20000, 17'd131071);
    // Tiny and near-full levels, and a plain mid-range color.
    send_color(15'd2000, 17'd1, 17'd1);
    send_color(15'd20000, 17'd65535, 17'd65535);
    send_color(15'd14000, 17'd50000, 17'd30000);
    wait_for_results();
  endtask

  // Random colors with random stalls on both sides. Halfway through the
  // sender pauses until every result is back, and the stall rate rises.
  task automatic test_random_colors();
    rx_mode      = RX_RANDOM;
    rx_stall_pct = 30;
    tx_max_gap   = 6;
    tx_max_burst = 12;
    send_random_colors(300);
    wait_for_results();
    rx_stall_pct = 60;
    tx_max_gap   = 3;
    tx_max_burst = 20;
    send_random_colors(300);
    wait_for_results();
  endtask

  // The receiver refuses results for a long stretch while the sender keeps
  // offering back to back, so the pipeline fills and the input must stall
  // without losing or repeating a color.
  task automatic test_output_hold_off();
    rx_mode      = RX_RANDOM;
    rx_stall_pct = 10;
    tx_max_gap   = 0;
    tx_max_burst = 64;
    hold_request = 200;
    send_random_colors(60);
    wait_for_results();
  endtask

  // The receiver stalls on a rotating 8-bit pattern while the sender
  // runs short bursts, so stalls and gaps land on every pipeline phase.
  task automatic test_stall_patterns();
    rx_mode      = RX_PATTERN;
    tx_max_gap   = 3;
    tx_max_burst = 5;
    repeat (5) begin
      rx_pattern = 8'($urandom_range(255, 1));
      send_random_colors(50);
    end
    wait_for_results();
  endtask

  // One color per clock with no stalls anywhere.
  task automatic test_full_rate();
    rx_mode      = RX_ALWAYS;
    tx_max_gap   = 0;
    tx_max_burst = 1000;
    send_random_colors(200);
    wait_for_results();
  endtask

  initial begin
    rst                <= 1'b1;
    pix_in.valid       <= 1'b0;
    pix_in.hue         <= '0;
    pix_in.lightness   <= '0;
    pix_in.saturation  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_directed_colors();
    test_random_colors();
    test_output_hold_off();
    test_stall_patterns();
    test_full_rate();

    // Give a stray extra result time to show up after the six-stage pipeline.
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("hls_to_rgb_converter_test passed");
    end else begin
      $display("hls_to_rgb_converter_test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/hlsrgb_pkg.sv
rtl/hlsrgb_if.sv
rtl/hlsrgb_prep.sv
rtl/hlsrgb_levels.sv
rtl/hlsrgb_ramp.sv
rtl/hls_to_rgb_converter.sv
bench/hls_to_rgb_converter_test.sv
